// File: sv/ssb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssb_pkg;

  // field widths
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned SRC_W   = 10;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned ADDR_W  = 20;

  // register port
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // color that marks a transparent source pixel
  localparam logic [COLOR_W-1:0] KEY_COLOR = 32'hFF00_0000;

  // reset values of the registers
  localparam logic [DIM_W-1:0] CANVAS_W_RST = 11'd640;
  localparam logic [DIM_W-1:0] CANVAS_H_RST = 11'd480;
  localparam logic [DIM_W-1:0] SPRITE_W_RST = 11'd32;
  localparam logic [DIM_W-1:0] SPRITE_H_RST = 11'd32;

  // register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_CANVAS_W = 3'd0,
    REG_CANVAS_H = 3'd1,
    REG_SPRITE_W = 3'd2,
    REG_SPRITE_H = 3'd3,
    REG_POS_X    = 3'd4,
    REG_POS_Y    = 3'd5,
    REG_MIRROR   = 3'd6
  } ssb_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0]        canvas_width;
    logic [DIM_W-1:0]        canvas_height;
    logic [DIM_W-1:0]        sprite_width;
    logic [DIM_W-1:0]        sprite_height;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    mirror;
  } ssb_cfg_t;

  typedef struct packed {
    logic [SRC_W-1:0]   src_col;
    logic [SRC_W-1:0]   src_row;
    logic [COLOR_W-1:0] pixel_color;
  } ssb_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  dest_addr;
    logic [COLOR_W-1:0] dest_color;
    logic               last_write;
  } ssb_out_t;

endpackage

`default_nettype wire

// File: sv/ssb_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module ssb_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssb_pkg::APB_AW-1:0] paddr,
  input  wire logic [ssb_pkg::APB_DW-1:0] pwdata,
  output logic      [ssb_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output ssb_pkg::ssb_cfg_t               cfg_o
);
  import ssb_pkg::*;

  ssb_cfg_t cfg_q;
  ssb_reg_e reg_idx;
  logic     wr_en;

  assign reg_idx = ssb_reg_e'(paddr[APB_AW-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.canvas_width  <= CANVAS_W_RST;
      cfg_q.canvas_height <= CANVAS_H_RST;
      cfg_q.sprite_width  <= SPRITE_W_RST;
      cfg_q.sprite_height <= SPRITE_H_RST;
      cfg_q.pos_x         <= '0;
      cfg_q.pos_y         <= '0;
      cfg_q.mirror        <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CANVAS_W: cfg_q.canvas_width  <= pwdata[DIM_W-1:0];
        REG_CANVAS_H: cfg_q.canvas_height <= pwdata[DIM_W-1:0];
        REG_SPRITE_W: cfg_q.sprite_width  <= pwdata[DIM_W-1:0];
        REG_SPRITE_H: cfg_q.sprite_height <= pwdata[DIM_W-1:0];
        REG_POS_X:    cfg_q.pos_x         <= $signed(pwdata[POS_W-1:0]);
        REG_POS_Y:    cfg_q.pos_y         <= $signed(pwdata[POS_W-1:0]);
        REG_MIRROR:   cfg_q.mirror        <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_CANVAS_W: prdata = APB_DW'(cfg_q.canvas_width);
      REG_CANVAS_H: prdata = APB_DW'(cfg_q.canvas_height);
      REG_SPRITE_W: prdata = APB_DW'(cfg_q.sprite_width);
      REG_SPRITE_H: prdata = APB_DW'(cfg_q.sprite_height);
      REG_POS_X:    prdata = APB_DW'($unsigned(cfg_q.pos_x));
      REG_POS_Y:    prdata = APB_DW'($unsigned(cfg_q.pos_y));
      REG_MIRROR:   prdata = APB_DW'(cfg_q.mirror);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/scaled_sprite_blit_core.sv
// Pipeline: input register, then job register, then the write walker that drives the output.
// Throughput: one write per cycle while out_stall_i is low; an item has 1 to
//   SCALE_FACTOR*SCALE_FACTOR surviving writes, items with none never occupy the
//   walker, and the input side takes one item per cycle while the walker keeps up.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none

module scaled_sprite_blit_core #(
  parameter int unsigned SCALE_FACTOR = 2,
  parameter int unsigned MAX_DIM      = 1024
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // source pixels
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire ssb_pkg::ssb_in_t           in_item_i,
  // destination writes
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output ssb_pkg::ssb_out_t               out_item_o,
  // register port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssb_pkg::APB_AW-1:0] paddr,
  input  wire logic [ssb_pkg::APB_DW-1:0] pwdata,
  output logic      [ssb_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import ssb_pkg::*;

  localparam int unsigned CNT_W   = (SCALE_FACTOR > 1) ? $clog2(SCALE_FACTOR) : 1;
  localparam int unsigned CRD_W   = 13 + $clog2(SCALE_FACTOR);
  localparam int unsigned CAP_INT = (MAX_DIM > 2047) ? 2047 : MAX_DIM;
  localparam logic [DIM_W-1:0]        DIM_CAP = DIM_W'(CAP_INT);
  localparam logic [CRD_W-1:0]        SCALE_C = CRD_W'(SCALE_FACTOR);
  localparam logic signed [CRD_W-1:0] SPAN    = CRD_W'(SCALE_FACTOR - 1);

  ssb_cfg_t cfg;

  ssb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // clamped sizes
  logic [DIM_W-1:0] cw, ch, sw, sh;
  assign cw = (cfg.canvas_width  > DIM_CAP) ? DIM_CAP : cfg.canvas_width;
  assign ch = (cfg.canvas_height > DIM_CAP) ? DIM_CAP : cfg.canvas_height;
  assign sw = (cfg.sprite_width  > DIM_CAP) ? DIM_CAP : cfg.sprite_width;
  assign sh = (cfg.sprite_height > DIM_CAP) ? DIM_CAP : cfg.sprite_height;

  // input register
  logic    in_valid_q;
  ssb_in_t in_q;

  // job register: clipped block of one source pixel
  logic               job_valid_q;
  logic [DIM_W-1:0]   job_x_q, job_y_q;
  logic [CNT_W-1:0]   job_na_q, job_nb_q;
  logic [COLOR_W-1:0] job_color_q;

  // write walker, doubles as the output register
  logic               busy_q;
  logic [ADDR_W-1:0]  addr_q, row_q;
  logic [CNT_W-1:0]   a_q, b_q, na_q, nb_q;
  logic [COLOR_W-1:0] color_q;

  // block placement and clipping
  logic                    src_ok, live_x, live_y, item_live;
  logic [DIM_W-1:0]        dcol;
  logic [CRD_W-1:0]        xoff, yoff;
  logic signed [CRD_W-1:0] x0, y0, x_end, y_end, x_first, y_first, x_last, y_last;
  logic signed [CRD_W-1:0] cw_s, ch_s, dx, dy;

  always_comb begin
    src_ok  = ({1'b0, in_q.src_col} < sw) && ({1'b0, in_q.src_row} < sh)
              && (in_q.pixel_color != KEY_COLOR);
    dcol    = cfg.mirror ? (sw - DIM_W'(1) - {1'b0, in_q.src_col}) : {1'b0, in_q.src_col};
    xoff    = CRD_W'(dcol) * SCALE_C;
    yoff    = CRD_W'(in_q.src_row) * SCALE_C;
    x0      = CRD_W'(cfg.pos_x) + $signed(xoff);
    y0      = CRD_W'(cfg.pos_y) + $signed(yoff);
    x_end   = x0 + SPAN;
    y_end   = y0 + SPAN;
    cw_s    = $signed(CRD_W'(cw));
    ch_s    = $signed(CRD_W'(ch));
    x_first = x0[CRD_W-1] ? '0 : x0;
    y_first = y0[CRD_W-1] ? '0 : y0;
    x_last  = (x_end >= cw_s) ? (cw_s - CRD_W'(1)) : x_end;
    y_last  = (y_end >= ch_s) ? (ch_s - CRD_W'(1)) : y_end;
    live_x  = !x_end[CRD_W-1] && (x_first < cw_s);
    live_y  = !y_end[CRD_W-1] && (y_first < ch_s);
    dx      = x_last - x_first;
    dy      = y_last - y_first;
    item_live = src_ok && live_x && live_y;
  end

  // handshake chain
  logic last, out_fire, walk_take, job_free, in_move, in_free, in_fire;

  assign last      = (a_q == na_q) && (b_q == nb_q);
  assign out_fire  = busy_q && !out_stall_i;
  assign walk_take = !busy_q || (out_fire && last);
  assign job_free  = !job_valid_q || walk_take;
  assign in_move   = in_valid_q && (!item_live || job_free);
  assign in_free   = !in_valid_q || in_move;
  assign in_fire   = in_valid_i && in_free;
  assign in_stall_o = !in_free;

  // start address of a block
  logic [2*DIM_W-1:0] row_prod;
  logic [ADDR_W-1:0]  start_addr;
  assign row_prod   = job_y_q * cw;
  assign start_addr = row_prod[ADDR_W-1:0] + ADDR_W'(job_x_q);

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      job_valid_q <= 1'b0;
      busy_q      <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid_q <= in_valid_i;
      end
      if (job_free) begin
        job_valid_q <= in_valid_q && item_live;
      end
      if (walk_take) begin
        busy_q <= job_valid_q;
      end
    end
  end

  // input and job payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_item_i;
    end
    if (job_free && in_valid_q && item_live) begin
      job_x_q     <= x_first[DIM_W-1:0];
      job_y_q     <= y_first[DIM_W-1:0];
      job_na_q    <= dx[CNT_W-1:0];
      job_nb_q    <= dy[CNT_W-1:0];
      job_color_q <= in_q.pixel_color;
    end
  end

  // walker: row by row, left to right
  always_ff @(posedge clk_i) begin
    if (walk_take) begin
      if (job_valid_q) begin
        addr_q  <= start_addr;
        row_q   <= start_addr;
        a_q     <= '0;
        b_q     <= '0;
        na_q    <= job_na_q;
        nb_q    <= job_nb_q;
        color_q <= job_color_q;
      end
    end else if (out_fire) begin
      if (a_q == na_q) begin
        a_q    <= '0;
        b_q    <= b_q + CNT_W'(1);
        row_q  <= row_q + ADDR_W'(cw);
        addr_q <= row_q + ADDR_W'(cw);
      end else begin
        a_q    <= a_q + CNT_W'(1);
        addr_q <= addr_q + ADDR_W'(1);
      end
    end
  end

  assign out_valid_o           = busy_q;
  assign out_item_o.dest_addr  = addr_q;
  assign out_item_o.dest_color = color_q;
  assign out_item_o.last_write = last;

endmodule

`default_nettype wire

// File: sv/ssb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ssb_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire ssb_pkg::ssb_out_t out_item_o
);
  import ssb_pkg::*;

  // a stalled write holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled write changed");

  // the writes of one item come without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last_write |=> out_valid_o)
    else $error("gap inside the writes of an item");

  // all writes of one item carry its color
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last_write |=> $stable(out_item_o.dest_color))
    else $error("color changed inside an item");

  // an idle output never backs up the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output idle");

endmodule

bind scaled_sprite_blit_core ssb_checker u_ssb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
